FILE: rtl/core/sss_pkg.sv
// Shared types and constants for the seven-segment scan sequencer.
package sss_pkg;

  localparam int DIGIT_COUNT  = 4;
  localparam int FRAME_COUNT  = 7;
  localparam int REG_FRAMES   = 7;
  localparam int WORD_W       = 32;
  localparam int SEG_W        = 8;
  localparam int INTERVAL_W   = 10;
  localparam int DIGIT_W      = 2;
  localparam int CFG_INDEX_W  = 4;
  localparam int POS_W        = $clog2(FRAME_COUNT + 1);
  localparam int FRAME_IDX_W  = $clog2(REG_FRAMES);

  typedef logic [WORD_W-1:0]      word_t;
  typedef logic [SEG_W-1:0]       seg_t;
  typedef logic [INTERVAL_W-1:0]  interval_t;
  typedef logic [DIGIT_W-1:0]     digit_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [POS_W-1:0]       pos_t;
  typedef logic [FRAME_IDX_W-1:0] frame_idx_t;

  // Register indexes: frame words occupy 0 .. REG_FRAMES-1.
  localparam cfg_index_t CFG_FRAME_LIMIT = cfg_index_t'(REG_FRAMES);
  localparam cfg_index_t CFG_INTERVAL    = cfg_index_t'(REG_FRAMES);

  localparam interval_t INTERVAL_RESET = interval_t'(600);

  // Position value that means no sequence is running.
  localparam pos_t POS_IDLE = pos_t'(FRAME_COUNT);
  localparam pos_t POS_FIRST = pos_t'(0);
  localparam digit_t DIGIT_LAST = digit_t'(DIGIT_COUNT - 1);

  typedef struct packed {
    word_t [REG_FRAMES-1:0] frames;
    interval_t              interval;
  } cfg_t;

  typedef struct packed {
    digit_t digit;
    seg_t   segments;
    logic   active;
  } result_t;

endpackage

FILE: rtl/core/sss_cfg_regs.sv
// Configuration register file holding the frame words and the frame interval.
module sss_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  sss_pkg::cfg_index_t cfg_index,
  input  sss_pkg::word_t     cfg_data,
  output sss_pkg::cfg_t      cfg
);

  sss_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.frames   <= '0;
      regs.interval <= sss_pkg::INTERVAL_RESET;
    end else if (cfg_write) begin
      if (cfg_index < sss_pkg::CFG_FRAME_LIMIT) begin
        regs.frames[sss_pkg::frame_idx_t'(cfg_index)] <= cfg_data;
      end else if (cfg_index == sss_pkg::CFG_INTERVAL) begin
        regs.interval <= cfg_data[sss_pkg::INTERVAL_W-1:0];
      end
    end
  end

  assign cfg = regs;

endmodule

FILE: rtl/core/sss_seq.sv
// Frame sequencer and digit scan: state update and segment selection per word.
module sss_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              show_request,
  input  sss_pkg::word_t    live_score_segments,
  input  sss_pkg::cfg_t     cfg,
  output sss_pkg::result_t  result
);

  sss_pkg::pos_t      pos, pos_next, pos_start;
  sss_pkg::interval_t interval_count, interval_count_next, count_inc;
  sss_pkg::word_t     shown_word, shown_word_next;
  sss_pkg::digit_t    digit_counter, digit_counter_next;
  sss_pkg::word_t     frame_sel;
  logic               active;

  always_comb begin
    pos_start           = show_request ? sss_pkg::POS_FIRST : pos;
    pos_next            = pos_start;
    interval_count_next = interval_count;
    shown_word_next     = shown_word;
    count_inc           = interval_count + 1'b1;
    frame_sel           = cfg.frames[sss_pkg::frame_idx_t'(pos_start)];
    active              = 1'b0;

    if (pos_start < sss_pkg::POS_IDLE) begin
      active = 1'b1;
      if (pos_start == sss_pkg::POS_FIRST) begin
        shown_word_next = frame_sel;
        pos_next        = pos_start + 1'b1;
      end else begin
        interval_count_next = count_inc;
        if (count_inc >= cfg.interval) begin
          shown_word_next     = frame_sel;
          pos_next            = pos_start + 1'b1;
          interval_count_next = '0;
        end
      end
    end else begin
      pos_next        = sss_pkg::POS_IDLE;
      shown_word_next = live_score_segments;
    end

    digit_counter_next = (digit_counter == sss_pkg::DIGIT_LAST) ? '0 : digit_counter + 1'b1;
  end

  always_comb begin
    result.digit  = digit_counter;
    result.active = active;
    case (digit_counter)
      2'd0:    result.segments = shown_word_next[31:24];
      2'd1:    result.segments = shown_word_next[23:16];
      2'd2:    result.segments = shown_word_next[15:8];
      default: result.segments = shown_word_next[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos            <= sss_pkg::POS_IDLE;
      interval_count <= '0;
      shown_word     <= '0;
      digit_counter  <= '0;
    end else if (step) begin
      pos            <= pos_next;
      interval_count <= interval_count_next;
      shown_word     <= shown_word_next;
      digit_counter  <= digit_counter_next;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= sss_pkg::POS_IDLE)
    else $error("frame position beyond idle");

  a_request_restarts: assert property (@(posedge clk) disable iff (rst)
    step && show_request |=> pos == sss_pkg::POS_FIRST + 1'b1)
    else $error("show request did not restart the sequence");

  a_idle_stays: assert property (@(posedge clk) disable iff (rst)
    step && !show_request && pos == sss_pkg::POS_IDLE |=> pos == sss_pkg::POS_IDLE)
    else $error("sequence left idle without a request");

endmodule

FILE: rtl/core/seven_segment_scan_sequencer_unit.sv
// Top level of the seven-segment scan sequencer.
//
// One word arrives on the tick channel per display refresh tick: a show
// request flag and the live score as four segment bytes. For each accepted
// word the block returns exactly one result word: the digit to drive, its
// segment byte (digit 0 takes the top byte of the word on display) and a flag
// that is high while the stored best-score frames are being played.
// A show request plays the seven frame words, the first at once and each
// later one after cfg.interval ticks; then the live score returns.
// Configuration is a plain write port: index 0 to 6 are the frame words,
// index 7 is the frame interval; other indexes are ignored.
// A word is captured in the input register; when it moves forward, the
// sequencer updates its state and loads the result register. Throughput is
// one word per cycle unless the receiver stalls, set by the single pass from
// input register to result register. When the receiver stalls, the result
// holds, the input register still takes one more word, and only then does
// tick_stall rise. Reset (rst, synchronous) empties both registers, blanks
// the display word, ends any sequence and restores the default interval.
module seven_segment_scan_sequencer_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  sss_pkg::cfg_index_t cfg_index,
  input  sss_pkg::word_t      cfg_data,
  input  logic                tick_valid,
  output logic                tick_stall,
  input  logic                show_request,
  input  sss_pkg::word_t      live_score_segments,
  output logic                result_valid,
  input  logic                result_stall,
  output sss_pkg::digit_t     digit_index,
  output sss_pkg::seg_t       segment_bits,
  output logic                best_sequence_active
);

  sss_pkg::cfg_t    cfg;
  sss_pkg::result_t result_comb;
  sss_pkg::result_t result_reg;

  // Input register.
  logic           s1_valid;
  logic           s1_request;
  sss_pkg::word_t s1_live;

  logic step;
  logic take_tick;

  // The held word moves forward when the result register is empty or is
  // being emptied in this same cycle.
  assign step       = s1_valid && (!result_valid || !result_stall);
  assign tick_stall = s1_valid && !step;
  assign take_tick  = tick_valid && !tick_stall;

  sss_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sss_seq u_seq (
    .clk                 (clk),
    .rst                 (rst),
    .step                (step),
    .show_request        (s1_request),
    .live_score_segments (s1_live),
    .cfg                 (cfg),
    .result              (result_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take_tick) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_tick) begin
      s1_request <= show_request;
      s1_live    <= live_score_segments;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result_reg <= result_comb;
    end
  end

  assign digit_index          = result_reg.digit;
  assign segment_bits         = result_reg.segments;
  assign best_sequence_active = result_reg.active;

  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    tick_stall |-> s1_valid && result_valid && result_stall)
    else $error("tick stall raised with room in the pipeline");

  a_held_word_kept: assert property (@(posedge clk) disable iff (rst)
    s1_valid && result_valid && result_stall |=> s1_valid)
    else $error("held input word lost while result stalled");

  a_step_fills_result: assert property (@(posedge clk) disable iff (rst)
    step |=> result_valid)
    else $error("processed word did not reach the result register");

endmodule
